>>> design/sta_pkg.sv
// Shared types and constants for the session table with aging.
package sta_pkg;

    // Fixed field widths on the stream ports
    localparam int KIND_W      = 2;
    localparam int TIME_W      = 32;
    localparam int KEY_FIELD_W = 64;
    localparam int TOK_FIELD_W = 64;
    localparam int USR_FIELD_W = 32;
    localparam int STATUS_W    = 2;
    localparam int SLOT_FIELD_W = 4;
    localparam int ACT_FIELD_W = 5;

    // Input tdata layout: current_time, session_key, new_token, user_tag
    localparam int IN_TIME_LSB = 0;
    localparam int IN_KEY_LSB  = IN_TIME_LSB + TIME_W;
    localparam int IN_TOK_LSB  = IN_KEY_LSB + KEY_FIELD_W;
    localparam int IN_USR_LSB  = IN_TOK_LSB + TOK_FIELD_W;
    localparam int IN_DATA_W   = IN_USR_LSB + USR_FIELD_W;

    // Output tdata layout: slot_index, found_user, found_token, active_sessions
    localparam int OUT_SLOT_LSB = 0;
    localparam int OUT_USR_LSB  = OUT_SLOT_LSB + SLOT_FIELD_W;
    localparam int OUT_TOK_LSB  = OUT_USR_LSB + USR_FIELD_W;
    localparam int OUT_ACT_LSB  = OUT_TOK_LSB + TOK_FIELD_W;
    localparam int OUT_USED_W   = OUT_ACT_LSB + ACT_FIELD_W;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE  = 2'd0,
        KIND_LOOKUP  = 2'd1,
        KIND_DESTROY = 2'd2,
        KIND_SWEEP   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EXPIRED   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Control that travels with a request along the cell row
    typedef struct packed {
        logic    valid;
        t_kind   kind;
        logic    hit;
        t_status status;
    } t_ctl;

endpackage

>>> design/sta_cell.sv
// One session slot cell: holds a slot and acts on the request passing through it.
module sta_cell #(
    parameter int SLOTS      = 16,
    parameter int INDEX      = 0,
    parameter int KEY_BITS   = 64,
    parameter int TOKEN_BITS = 64,
    parameter int USER_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sta_pkg::TIME_W-1:0]    i_timeout,
    input  sta_pkg::t_ctl                 i_ctl,
    input  logic [sta_pkg::TIME_W-1:0]    i_time,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [TOKEN_BITS-1:0]         i_tok,
    input  logic [USER_BITS-1:0]          i_user,
    input  logic [$clog2(SLOTS+1)-1:0]    i_cnt,
    input  logic [$clog2(SLOTS)-1:0]      i_idx,
    input  logic [USER_BITS-1:0]          i_res_user,
    input  logic [TOKEN_BITS-1:0]         i_res_tok,
    output sta_pkg::t_ctl                 o_ctl,
    output logic [sta_pkg::TIME_W-1:0]    o_time,
    output logic [KEY_BITS-1:0]           o_key,
    output logic [TOKEN_BITS-1:0]         o_tok,
    output logic [USER_BITS-1:0]          o_user,
    output logic [$clog2(SLOTS+1)-1:0]    o_cnt,
    output logic [$clog2(SLOTS)-1:0]      o_idx,
    output logic [USER_BITS-1:0]          o_res_user,
    output logic [TOKEN_BITS-1:0]         o_res_tok
);
    import sta_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(INDEX);

    // Slot contents
    logic                  r_act, n_act;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [TOKEN_BITS-1:0] r_tok, n_tok;
    logic [USER_BITS-1:0]  r_user, n_user;
    logic [TIME_W-1:0]     r_last, n_last;

    // Request stage handed to the next cell
    t_ctl                  r_ctl, n_ctl;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [USER_BITS-1:0]  r_res_user, n_res_user;
    logic [TOKEN_BITS-1:0] r_res_tok, n_res_tok;
    logic [TIME_W-1:0]     r_time;
    logic [KEY_BITS-1:0]   r_key_fwd;
    logic [TOKEN_BITS-1:0] r_tok_fwd;
    logic [USER_BITS-1:0]  r_user_fwd;

    logic [TIME_W-1:0]     w_age;
    logic                  w_stale;
    logic                  w_match;

    // Age with wrapping subtraction
    assign w_age   = i_time - r_last;
    assign w_stale = r_act && (w_age > i_timeout);
    assign w_match = r_act && (r_key == i_key);

    // Apply the request to this slot
    always_comb begin
        n_act      = r_act;
        n_key      = r_key;
        n_tok      = r_tok;
        n_user     = r_user;
        n_last     = r_last;
        n_ctl      = i_ctl;
        n_cnt      = i_cnt;
        n_idx      = i_idx;
        n_res_user = i_res_user;
        n_res_tok  = i_res_tok;
        if (i_ctl.valid) begin
            case (i_ctl.kind)
                KIND_CREATE: begin
                    if (w_stale) begin
                        n_act = 1'b0;
                        n_cnt = n_cnt - CNT_W'(1);
                    end
                    if (!i_ctl.hit && !(r_act && !w_stale)) begin
                        n_act      = 1'b1;
                        n_key      = i_key;
                        n_tok      = i_tok;
                        n_user     = i_user;
                        n_last     = i_time;
                        n_cnt      = n_cnt + CNT_W'(1);
                        n_ctl.hit  = 1'b1;
                        n_idx      = CELL_IDX;
                        n_res_user = i_user;
                        n_res_tok  = i_tok;
                    end
                end
                KIND_LOOKUP: begin
                    if (!i_ctl.hit && w_match) begin
                        n_ctl.hit = 1'b1;
                        if (w_stale) begin
                            n_act        = 1'b0;
                            n_cnt        = i_cnt - CNT_W'(1);
                            n_ctl.status = ST_EXPIRED;
                        end else begin
                            n_last     = i_time;
                            n_idx      = CELL_IDX;
                            n_res_user = r_user;
                            n_res_tok  = r_tok;
                        end
                    end
                end
                KIND_DESTROY: begin
                    if (!i_ctl.hit && w_match) begin
                        n_ctl.hit  = 1'b1;
                        n_act      = 1'b0;
                        n_cnt      = i_cnt - CNT_W'(1);
                        n_idx      = CELL_IDX;
                        n_res_user = r_user;
                        n_res_tok  = r_tok;
                    end
                end
                KIND_SWEEP: begin
                    if (w_stale) begin
                        n_act = 1'b0;
                        n_cnt = i_cnt - CNT_W'(1);
                    end
                end
                default: begin
                    n_ctl = i_ctl;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ctl <= '0;
        end else begin
            r_act <= n_act;
            r_ctl <= n_ctl;
        end
    end

    // Slot payload and forwarded request fields
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_tok      <= n_tok;
        r_user     <= n_user;
        r_last     <= n_last;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_res_user <= n_res_user;
        r_res_tok  <= n_res_tok;
        r_time     <= i_time;
        r_key_fwd  <= i_key;
        r_tok_fwd  <= i_tok;
        r_user_fwd <= i_user;
    end

    assign o_ctl      = r_ctl;
    assign o_time     = r_time;
    assign o_key      = r_key_fwd;
    assign o_tok      = r_tok_fwd;
    assign o_user     = r_user_fwd;
    assign o_cnt      = r_cnt;
    assign o_idx      = r_idx;
    assign o_res_user = r_res_user;
    assign o_res_tok  = r_res_tok;

endmodule

>>> design/session_table_with_aging_unit.sv
// Top level: session table with idle-timeout aging built as a row of slot cells.
//
// Channel   Direction  Handshake               Contents
// request   in         i_s_tvalid/o_s_tready   tuser kind, tdata time/key/token/user
// result    out        o_m_tvalid/i_m_tready   tuser status, tdata slot/user/token/count
// config    in         i_cfg_we                i_cfg_wdata idle timeout in seconds
//
// A request walks the cell row, one slot per cycle; its result is registered into the
// output buffer when it leaves the last cell, and no new request is taken until it
// has left the row, so requests pass through the row one at a time.
// A result stalled at the output moves to a second buffer; no request is taken
// while that buffer is full.
// Reset clears all slots, the active count and sets the timeout to 1800.
module session_table_with_aging_unit #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 64,
    parameter int TOKEN_BITS = 64,
    parameter int USER_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [31:0] current_time, [95:32] session_key, [159:96] new_token,
    // [191:160] user_tag
    input  logic [sta_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // [1:0] kind
    input  logic [sta_pkg::KIND_W-1:0]         i_s_tuser,
    // result
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [3:0] slot_index, [35:4] found_user, [99:36] found_token,
    // [104:100] active_sessions, [111:105] zero
    output logic [sta_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // [1:0] status
    output logic [sta_pkg::STATUS_W-1:0]       o_m_tuser,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [sta_pkg::TIME_W-1:0]         i_cfg_wdata
);
    import sta_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1800;

    logic [TIME_W-1:0]     r_timeout;
    logic [CNT_W-1:0]      r_active_total;
    logic                  r_busy;
    logic                  r_out_valid;
    logic                  r_pend_valid;
    logic [OUT_DATA_W-1:0] r_out_data, r_pend_data;
    logic [STATUS_W-1:0]   r_out_user, r_pend_user;

    logic                  w_accept;
    logic                  w_fin;
    logic                  w_out_free;
    t_status               w_status;
    logic [OUT_DATA_W-1:0] w_fin_data;

    // Request as it travels along the row; entry k feeds cell k
    t_ctl                  w_ctl      [SLOTS+1];
    logic [TIME_W-1:0]     w_time     [SLOTS+1];
    logic [KEY_BITS-1:0]   w_key      [SLOTS+1];
    logic [TOKEN_BITS-1:0] w_tok      [SLOTS+1];
    logic [USER_BITS-1:0]  w_user     [SLOTS+1];
    logic [CNT_W-1:0]      w_cnt      [SLOTS+1];
    logic [IDX_W-1:0]      w_idx      [SLOTS+1];
    logic [USER_BITS-1:0]  w_res_user [SLOTS+1];
    logic [TOKEN_BITS-1:0] w_res_tok  [SLOTS+1];

    assign o_s_tready = !r_busy && !r_pend_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Launch a request into the first cell
    always_comb begin
        w_ctl[0].valid  = w_accept;
        w_ctl[0].kind   = t_kind'(i_s_tuser);
        w_ctl[0].hit    = 1'b0;
        w_ctl[0].status = ST_OK;
    end
    assign w_time[0]     = i_s_tdata[IN_TIME_LSB +: TIME_W];
    assign w_key[0]      = KEY_BITS'(i_s_tdata[IN_KEY_LSB +: KEY_FIELD_W]);
    assign w_tok[0]      = TOKEN_BITS'(i_s_tdata[IN_TOK_LSB +: TOK_FIELD_W]);
    assign w_user[0]     = USER_BITS'(i_s_tdata[IN_USR_LSB +: USR_FIELD_W]);
    assign w_cnt[0]      = r_active_total;
    assign w_idx[0]      = '0;
    assign w_res_user[0] = '0;
    assign w_res_tok[0]  = '0;

    // Row of slot cells
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        sta_cell #(
            .SLOTS      (SLOTS),
            .INDEX      (k),
            .KEY_BITS   (KEY_BITS),
            .TOKEN_BITS (TOKEN_BITS),
            .USER_BITS  (USER_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_timeout  (r_timeout),
            .i_ctl      (w_ctl[k]),
            .i_time     (w_time[k]),
            .i_key      (w_key[k]),
            .i_tok      (w_tok[k]),
            .i_user     (w_user[k]),
            .i_cnt      (w_cnt[k]),
            .i_idx      (w_idx[k]),
            .i_res_user (w_res_user[k]),
            .i_res_tok  (w_res_tok[k]),
            .o_ctl      (w_ctl[k+1]),
            .o_time     (w_time[k+1]),
            .o_key      (w_key[k+1]),
            .o_tok      (w_tok[k+1]),
            .o_user     (w_user[k+1]),
            .o_cnt      (w_cnt[k+1]),
            .o_idx      (w_idx[k+1]),
            .o_res_user (w_res_user[k+1]),
            .o_res_tok  (w_res_tok[k+1])
        );
    end

    // Finish the result at the end of the row
    assign w_fin = w_ctl[SLOTS].valid;

    always_comb begin
        w_status = w_ctl[SLOTS].status;
        if (!w_ctl[SLOTS].hit) begin
            case (w_ctl[SLOTS].kind)
                KIND_CREATE:  w_status = ST_FULL;
                KIND_LOOKUP:  w_status = ST_NOT_FOUND;
                KIND_DESTROY: w_status = ST_NOT_FOUND;
                default:      w_status = w_ctl[SLOTS].status;
            endcase
        end
    end

    always_comb begin
        w_fin_data = '0;
        w_fin_data[OUT_SLOT_LSB +: SLOT_FIELD_W] = SLOT_FIELD_W'(w_idx[SLOTS]);
        w_fin_data[OUT_USR_LSB +: USR_FIELD_W]   = USR_FIELD_W'(w_res_user[SLOTS]);
        w_fin_data[OUT_TOK_LSB +: TOK_FIELD_W]   = TOK_FIELD_W'(w_res_tok[SLOTS]);
        w_fin_data[OUT_ACT_LSB +: ACT_FIELD_W]   = ACT_FIELD_W'(w_cnt[SLOTS]);
    end

    assign w_out_free = !r_out_valid || i_m_tready;

    // Control: timeout register, count, busy flag and output buffers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout      <= TIMEOUT_RESET;
            r_active_total <= '0;
            r_busy         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_pend_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end
            if (w_fin) begin
                r_active_total <= w_cnt[SLOTS];
            end
            if (w_out_free) begin
                if (r_pend_valid) begin
                    r_out_valid  <= 1'b1;
                    r_pend_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_fin;
                end
            end else if (w_fin) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    // Output payload: load from the buffer or straight from the row
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_pend_valid) begin
                r_out_data <= r_pend_data;
                r_out_user <= r_pend_user;
            end else if (w_fin) begin
                r_out_data <= w_fin_data;
                r_out_user <= w_status;
            end
        end else if (w_fin) begin
            r_pend_data <= w_fin_data;
            r_pend_user <= w_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule
